### src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Sizes, operation and status codes, controller states and cell buses.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int FP_W     = 7;
  localparam int LEN_W    = 8;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_SEARCH = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE
  } action_t;

  // broadcast to every cell
  typedef struct packed {
    action_t                   act;
    logic                      rd;
    logic                      srch;
    logic [POS_W-1:0]          pos;
    logic signed [WORD_W-1:0]  val;
    logic [CNT_W-1:0]          count;
  } sle_ctrl_t;

  // first-hit token passed from cell to cell toward cell 0
  typedef struct packed {
    logic                      hit;
    logic signed [WORD_W-1:0]  word;
    logic [IDX_W-1:0]          idx;
  } sle_res_t;

endpackage

`default_nettype wire

### src/sle_if.sv
// ----------------------------------------------------------------------------
// sle_if: item channels of the sequential list engine
// Request channel (operation) and response channel (result), valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sle_pkg::FUNC_W-1:0]           func;
  logic [sle_pkg::POS_W-1:0]            position;
  logic signed [sle_pkg::WORD_W-1:0]    value;

  modport source (output valid, output func, output position, output value,
                  input ready);
  modport sink   (input valid, input func, input position, input value,
                  output ready);
endinterface

interface sle_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [sle_pkg::STAT_W-1:0]           status;
  logic signed [sle_pkg::WORD_W-1:0]    read_value;
  logic [sle_pkg::FP_W-1:0]             found_position;
  logic [sle_pkg::LEN_W-1:0]            length;

  modport source (output valid, output status, output read_value,
                  output found_position, output length, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input length, output ready);
endinterface

`default_nettype wire

### src/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one list entry
// Holds a word, shifts with its neighbors on insert/delete, and relays the
// first-hit token for read and search toward cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell (
  input  wire logic                               clk,
  input  wire sle_pkg::sle_ctrl_t                 ctrl,
  input  wire logic [sle_pkg::IDX_W-1:0]          idx,
  input  wire logic signed [sle_pkg::WORD_W-1:0]  left_word,
  input  wire logic signed [sle_pkg::WORD_W-1:0]  right_word,
  output logic signed [sle_pkg::WORD_W-1:0]       word,
  input  wire sle_pkg::sle_res_t                  res_in,
  output sle_pkg::sle_res_t                       res_out
);

  logic signed [sle_pkg::WORD_W-1:0] word_next;
  sle_pkg::sle_res_t                 res_next;
  logic [sle_pkg::CMP_W-1:0]         my_idx;
  logic [sle_pkg::CMP_W-1:0]         pos;
  logic [sle_pkg::CMP_W-1:0]         count;
  logic                              hit;

  assign my_idx = sle_pkg::CMP_W'(idx);
  assign pos    = sle_pkg::CMP_W'(ctrl.pos);
  assign count  = sle_pkg::CMP_W'(ctrl.count);

  always_comb begin
    word_next = word;
    unique case (ctrl.act)
      sle_pkg::ACT_INSERT: begin
        if (my_idx == pos) begin
          word_next = ctrl.val;
        end else if (my_idx > pos) begin
          word_next = left_word;
        end
      end
      sle_pkg::ACT_DELETE: begin
        if (my_idx >= pos) begin
          word_next = right_word;
        end
      end
      default: word_next = word;
    endcase
  end

  assign hit = (ctrl.rd && (my_idx == pos)) ||
               (ctrl.srch && (word == ctrl.val) && (my_idx < count));

  always_comb begin
    if (hit) begin
      res_next.hit  = 1'b1;
      res_next.word = word;
      res_next.idx  = idx;
    end else begin
      res_next = res_in;
    end
  end

  always_ff @(posedge clk) begin
    word    <= word_next;
    res_out <= res_next;
  end

endmodule

`default_nettype wire

### src/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list of signed words in a row of cells
// Insert, delete, read at position and search by value, one result per item.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          accepted when
//  req      in   func, position, value                            valid & ready
//  rsp      out  status, read_value, found_position, length       valid & ready
//
//  Insert/delete: command register, then parallel shift in the commit state.
//  Read/search: scan, then commit; the hit token ripples one cell per cycle.
//  One item is in flight; req.ready is high in idle even while a result waits.
//  A stalled rsp holds the engine in its commit cycle; the list is unchanged.
//  Synchronous reset empties the list; entry words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_engine (
  input  wire logic clk,
  input  wire logic rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  sle_pkg::state_t                    state, state_next;
  logic [sle_pkg::CNT_W-1:0]          count, count_next;
  logic [sle_pkg::IDX_W-1:0]          scan_cnt, scan_cnt_next;
  sle_pkg::func_t                     cmd_func;
  logic [sle_pkg::POS_W-1:0]          cmd_pos;
  logic signed [sle_pkg::WORD_W-1:0]  cmd_val;

  logic                               out_valid;
  logic [sle_pkg::STAT_W-1:0]         out_status;
  logic signed [sle_pkg::WORD_W-1:0]  out_read;
  logic [sle_pkg::FP_W-1:0]           out_fp;
  logic [sle_pkg::LEN_W-1:0]          out_len;

  logic                               accept, slot_free, load_out;
  sle_pkg::status_t                   res_status;
  logic signed [sle_pkg::WORD_W-1:0]  res_read;
  logic [sle_pkg::FP_W-1:0]           res_fp;
  logic [sle_pkg::CMP_W-1:0]          pos_x, count_x;
  sle_pkg::sle_ctrl_t                 ctrl;

  logic signed [sle_pkg::WORD_W-1:0]  cell_word [sle_pkg::CAPACITY];
  sle_pkg::sle_res_t                  cell_res  [sle_pkg::CAPACITY+1];

  assign req.ready = (state == sle_pkg::ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign pos_x     = sle_pkg::CMP_W'(cmd_pos);
  assign count_x   = sle_pkg::CMP_W'(count);

  // result of the held command
  always_comb begin
    res_status = sle_pkg::STAT_OK;
    res_read   = '0;
    res_fp     = '0;
    unique case (cmd_func)
      sle_pkg::FUNC_INSERT: begin
        if (pos_x > count_x) begin
          res_status = sle_pkg::STAT_RANGE;
        end else if (count >= sle_pkg::CNT_W'(sle_pkg::CAPACITY)) begin
          res_status = sle_pkg::STAT_FULL;
        end
      end
      sle_pkg::FUNC_DELETE: begin
        if (pos_x >= count_x) begin
          res_status = sle_pkg::STAT_RANGE;
        end
      end
      sle_pkg::FUNC_READ: begin
        if (pos_x >= count_x) begin
          res_status = sle_pkg::STAT_RANGE;
        end else begin
          res_read = cell_res[0].word;
        end
      end
      sle_pkg::FUNC_SEARCH: begin
        if (cell_res[0].hit) begin
          res_fp = sle_pkg::FP_W'(cell_res[0].idx);
        end else begin
          res_status = sle_pkg::STAT_MISS;
        end
      end
      default: res_status = sle_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    count_next    = count;
    load_out      = 1'b0;
    ctrl.act      = sle_pkg::ACT_HOLD;
    ctrl.rd       = (cmd_func == sle_pkg::FUNC_READ);
    ctrl.srch     = (cmd_func == sle_pkg::FUNC_SEARCH);
    ctrl.pos      = cmd_pos;
    ctrl.val      = cmd_val;
    ctrl.count    = count;
    unique case (state)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          scan_cnt_next = '0;
          if ((req.func == sle_pkg::FUNC_READ) || (req.func == sle_pkg::FUNC_SEARCH)) begin
            state_next = sle_pkg::ST_SCAN;
          end else begin
            state_next = sle_pkg::ST_COMMIT;
          end
        end
      end
      sle_pkg::ST_SCAN: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == sle_pkg::IDX_W'(sle_pkg::CAPACITY - 1)) begin
          state_next = sle_pkg::ST_COMMIT;
        end
      end
      sle_pkg::ST_COMMIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = sle_pkg::ST_IDLE;
          if (res_status == sle_pkg::STAT_OK) begin
            if (cmd_func == sle_pkg::FUNC_INSERT) begin
              ctrl.act   = sle_pkg::ACT_INSERT;
              count_next = count + 1'b1;
            end else if (cmd_func == sle_pkg::FUNC_DELETE) begin
              ctrl.act   = sle_pkg::ACT_DELETE;
              count_next = count - 1'b1;
            end
          end
        end
      end
      default: state_next = sle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sle_pkg::ST_IDLE;
      count     <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func <= sle_pkg::func_t'(req.func);
      cmd_pos  <= req.position;
      cmd_val  <= req.value;
    end
    if (load_out) begin
      out_status <= res_status;
      out_read   <= res_read;
      out_fp     <= res_fp;
      out_len    <= sle_pkg::LEN_W'(count_next);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = out_read;
  assign rsp.found_position = out_fp;
  assign rsp.length         = out_len;

  assign cell_res[sle_pkg::CAPACITY] = '0;

  for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
    logic signed [sle_pkg::WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == sle_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    sle_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (sle_pkg::IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .res_in     (cell_res[i+1]),
      .res_out    (cell_res[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
    else $error("list length above capacity");

  a_count_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ($past(state) != sle_pkg::ST_COMMIT)) |-> $stable(count))
    else $error("list length changed outside commit");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != sle_pkg::STAT_OK)) |->
      ((out_read == '0) && (out_fp == '0)))
    else $error("nonzero payload on error result");

endmodule

`default_nettype wire

### sim/sequential_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequential_list_engine_tb: self-checking bench of the sequential list engine
// Directed operations on an empty and short list, then random phases that
// fill the list to capacity, work it while full, empty it and mix freely.
// Replies are compared field by field to typed rows or a behavioral list model.
// ----------------------------------------------------------------------------

module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int RANDOM_OPS  = 1650;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  read_value;
    logic [FP_W-1:0]           found_position;
    logic [LEN_W-1:0]          length;
  } list_reply_t;

  typedef struct packed {
    func_t                     func;
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  value;
    logic                      typed;
    list_reply_t               reply;
  } op_row_t;

  typedef enum int {PH_GROW, PH_FULL, PH_SHRINK, PH_MIXED} phase_e;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk = 1'b0;
  logic rst;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  sequential_list_engine i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // list model state
  logic signed [WORD_W-1:0] list_mem [CAPACITY];
  int                       list_len;

  list_reply_t replies_due[$];
  int          ops_sent;
  int          replies_checked;
  int          mismatch_count;
  int          fill_count;
  int          burst_left;
  int          op_count   [4];
  int          stat_count [4];
  int          cycle_count;

  // directed operations; typed rows carry their reply, the rest use the model
  op_row_t directed_ops [N_DIRECTED] = '{
    '{FUNC_READ,   8'd0,   32'sd0,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd0}},
    '{FUNC_DELETE, 8'd0,   32'sd0,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd0}},
    '{FUNC_SEARCH, 8'd0,   32'sd0,          1'b1, '{STAT_MISS,  32'sd0, 7'd0, 8'd0}},
    '{FUNC_INSERT, 8'd1,   32'sd5,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd0}},
    '{FUNC_INSERT, 8'd255, 32'sd5,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd0}},
    '{FUNC_INSERT, 8'd0,   32'sh7FFF_FFFF,  1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd1}},
    '{FUNC_INSERT, 8'd0,   32'sh8000_0000,  1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd2}},
    '{FUNC_INSERT, 8'd2,   -32'sd1,         1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd3}},
    '{FUNC_INSERT, 8'd1,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd4}},
    '{FUNC_READ,   8'd0,   32'sd0,          1'b1,
      '{STAT_OK, 32'sh8000_0000, 7'd0, 8'd4}},
    '{FUNC_READ,   8'd3,   32'sd0,          1'b1, '{STAT_OK,    -32'sd1, 7'd0, 8'd4}},
    '{FUNC_READ,   8'd4,   32'sd0,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd4}},
    '{FUNC_READ,   8'd255, 32'sd0,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd4}},
    '{FUNC_SEARCH, 8'd0,   -32'sd1,         1'b1, '{STAT_OK,    32'sd0, 7'd3, 8'd4}},
    '{FUNC_SEARCH, 8'd0,   32'sh8000_0000,  1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd4}},
    '{FUNC_SEARCH, 8'd9,   32'sd12345,      1'b1, '{STAT_MISS,  32'sd0, 7'd0, 8'd4}},
    '{FUNC_INSERT, 8'd4,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd5}},
    '{FUNC_SEARCH, 8'd0,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd1, 8'd5}},
    '{FUNC_DELETE, 8'd5,   32'sd0,          1'b1, '{STAT_RANGE, 32'sd0, 7'd0, 8'd5}},
    '{FUNC_DELETE, 8'd1,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd4}},
    '{FUNC_READ,   8'd1,   32'sd0,          1'b1,
      '{STAT_OK, 32'sh7FFF_FFFF, 7'd0, 8'd4}},
    '{FUNC_SEARCH, 8'd0,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd3, 8'd4}},
    '{FUNC_DELETE, 8'd0,   32'sd0,          1'b1, '{STAT_OK,    32'sd0, 7'd0, 8'd3}},
    '{FUNC_INSERT, 8'd3,   32'sh5A5A_A5A5,  1'b0, '0},
    '{FUNC_SEARCH, 8'd128, 32'sh5A5A_A5A5,  1'b0, '0}
  };

  function automatic list_reply_t apply_list_op(func_t op, logic [POS_W-1:0] pos,
                                                logic signed [WORD_W-1:0] val);
    list_reply_t r;
    r = '0;
    r.status = STAT_OK;
    case (op)
      FUNC_INSERT: begin
        if (int'(pos) > list_len) begin
          r.status = STAT_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      FUNC_DELETE: begin
        if (int'(pos) >= list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      FUNC_READ: begin
        if (int'(pos) >= list_len) r.status = STAT_RANGE;
        else r.read_value = list_mem[pos];
      end
      default: begin
        r.status = STAT_MISS;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.status = STAT_OK;
            r.found_position = FP_W'(i);
            break;
          end
        end
      end
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value(bit for_search);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (list_len > 0 && roll < (for_search ? 60 : 15))
      return list_mem[$urandom_range(0, list_len - 1)];
    if (roll >= 90) begin
      case ($urandom_range(0, 3))
        0: return 32'sd0;
        1: return -32'sd1;
        2: return 32'sh8000_0000;
        default: return 32'sh7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // sender bursts with random gaps, now and then a long burst with no gap
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  task automatic send_op(func_t op, logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] val,
                         logic typed, list_reply_t reply);
    list_reply_t pred;
    req_ch.valid    <= 1'b1;
    req_ch.func     <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    pred = apply_list_op(op, pos, val);
    replies_due.push_back(typed ? reply : pred);
    op_count[int'(op)]++;
    stat_count[int'(pred.status)]++;
    ops_sent++;
    pace_sender();
  endtask

  task automatic random_op(phase_e ph);
    int                       roll;
    func_t                    op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (roll < 78) op = FUNC_INSERT;
        else if (roll < 84) op = FUNC_DELETE;
        else if (roll < 92) op = FUNC_READ;
        else op = FUNC_SEARCH;
      end
      PH_SHRINK: begin
        if (roll < 75) op = FUNC_DELETE;
        else if (roll < 80) op = FUNC_INSERT;
        else if (roll < 90) op = FUNC_READ;
        else op = FUNC_SEARCH;
      end
      PH_FULL: begin
        if (roll < 30) op = FUNC_INSERT;
        else if (roll < 55) op = FUNC_READ;
        else if (roll < 90) op = FUNC_SEARCH;
        else op = FUNC_DELETE;
      end
      default: op = func_t'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 99) < ((ph == PH_MIXED) ? 25 : 6))
      pos = $urandom_range(0, 255);
    else if (op == FUNC_INSERT)
      pos = $urandom_range(0, list_len);
    else
      pos = (list_len == 0) ? '0 : $urandom_range(0, list_len - 1);
    val = pick_value(op == FUNC_SEARCH);
    send_op(op, pos, val, 1'b0, '0);
  endtask

  task automatic wait_replies_done();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // reply checker
  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_checked++;
      if (replies_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected reply status %0d read %0d pos %0d len %0d", $realtime,
                   rsp_ch.status, rsp_ch.read_value, rsp_ch.found_position, rsp_ch.length);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value ||
            rsp_ch.found_position !== want.found_position ||
            rsp_ch.length !== want.length) begin
          if (mismatch_count < 10)
            $display("%0t: reply %0d exp status %0d read %0d pos %0d len %0d, got %0d %0d %0d %0d",
                     $realtime, replies_checked, want.status, want.read_value,
                     want.found_position, want.length, rsp_ch.status, rsp_ch.read_value,
                     rsp_ch.found_position, rsp_ch.length);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stalls: open, random or a fixed rotating pattern
  initial begin : rx_pace
    rx_mode_e    rx_mode;
    int          rx_left;
    logic [15:0] rx_pattern;
    rx_mode    = RX_OPEN;
    rx_left    = 50;
    rx_pattern = 16'b1011_0110_1110_0101;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 400);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        default:   rsp_ch.ready <= rx_pattern[0];
      endcase
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("sequential_list_engine_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.func     = FUNC_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    list_len        = 0;
    burst_left      = 8;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i])
      send_op(directed_ops[i].func, directed_ops[i].position, directed_ops[i].value,
              directed_ops[i].typed, directed_ops[i].reply);
    wait_replies_done();

    while (ops_sent < N_DIRECTED + RANDOM_OPS) begin
      while (list_len < CAPACITY) random_op(PH_GROW);
      fill_count++;
      wait_replies_done();
      repeat (20) random_op(PH_FULL);
      wait_replies_done();
      while (list_len > 0) random_op(PH_SHRINK);
      wait_replies_done();
      repeat (200) random_op(PH_MIXED);
      wait_replies_done();
    end

    repeat (CAPACITY + 8) @(posedge clk);

    $display("%0d operations: %0d insert, %0d delete, %0d read, %0d search; %0d replies checked",
             ops_sent, op_count[FUNC_INSERT], op_count[FUNC_DELETE], op_count[FUNC_READ],
             op_count[FUNC_SEARCH], replies_checked);
    $display("list filled %0d times; %0d ok, %0d range, %0d full, %0d miss; %0d mismatches",
             fill_count, stat_count[STAT_OK], stat_count[STAT_RANGE], stat_count[STAT_FULL],
             stat_count[STAT_MISS], mismatch_count);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("sequential_list_engine_tb OK");
    end else begin
      $display("sequential_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
